/* design/eprf_pkg.sv */
// Shared types, codes and constants of the echo pulse range filter.
package eprf_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int WIDTH_BITS      = 16;
  localparam int MISS_BITS       = 8;
  localparam int SCALE_BITS      = 16;
  localparam int CM_BITS         = 11;
  localparam int DIGIT_BITS      = 4;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [MISS_BITS-1:0]  MISS_LIMIT_RST   = 8'd3;
  localparam logic [SCALE_BITS-1:0] TENTHS_SCALE_RST = 16'd11703;
  localparam logic [MISS_BITS-1:0]  MISS_MAX         = 8'hff;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX        = 16'hffff;

  // Q16 factor from tenths to whole centimeters.
  localparam logic [12:0] CM_FACTOR = 13'd6554;
  // Reciprocal of ten: (x * DIV10_MUL) >> DIV10_SHIFT equals x / 10 for 16-bit x.
  localparam logic [15:0] DIV10_MUL   = 16'hcccd;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [CM_BITS-1:0] CM_SAT = 11'h7ff;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_POLL = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MISS_LIMIT   = 1'd0,
    REG_TENTHS_SCALE = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCALE = 2'd1,
    ST_CM    = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;     // an input item is taken this cycle
    logic ld_tenths;  // register the scaled tenths value
    logic ld_cm;      // register centimeters and tenths digit
    logic load_out;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic poll_update;  // a poll now would update the filter
  } stat_t;

endpackage

/* design/echo_pulse_range_filter.sv */
// Top level of the echo pulse range filter: controller, datapath and checks.
// This block times ultrasonic echo pulses against a free-running tick counter and turns
// them into a smoothed distance. Each item carries an op: a tick advances the counter, an
// edge item with level high latches the pulse start and with level low stores the pulse
// width, and a poll folds the latest width in at three-quarter weight when a fresh pulse
// was seen or the miss count has passed miss_limit. An updating poll yields one result
// item with whole centimeters, the tenths digit, the filtered width in ticks and a flag
// that marks an update forced without an echo. After a tick, an edge or a poll that does not
// update, the next item follows at once. An updating poll holds off the next item while it
// steps through the two multiply stages of the distance path and the load of the output
// register, and its last stage waits while an earlier result item is still held in the
// output register. Configuration writes take effect from the cycle after they are made.
module echo_pulse_range_filter import eprf_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic                     in_echo_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CM_BITS-1:0]       out_distance_cm,
  output logic [DIGIT_BITS-1:0]    out_distance_tenths,
  output logic [WIDTH_BITS-1:0]    out_filtered_ticks,
  output logic                     out_timed_out
);

  cmd_t  cmd;
  stat_t stat;

  // The controller decides when an item is taken and steps an updating poll
  // through the scale, centimeter and output stages.
  eprf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds all measurement state and the configuration registers.
  eprf_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_echo_level       (in_echo_level),
    .cmd                 (cmd),
    .stat                (stat),
    .out_distance_cm     (out_distance_cm),
    .out_distance_tenths (out_distance_tenths),
    .out_filtered_ticks  (out_filtered_ticks),
    .out_timed_out       (out_timed_out)
  );

  // An updating poll must hold off the next item while its result is computed.
  a_poll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_op == OP_POLL && stat.poll_update) |=> in_stall)
    else $error("input not stalled after an updating poll");

  // The tenths digit is a remainder of ten.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_tenths <= 4'd9))
    else $error("tenths digit out of range");

  // Loading the output register always presents a result item.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("waiting result overwritten");

endmodule

/* design/eprf_datapath.sv */
// Datapath: counter, pulse capture, filter, miss count and distance arithmetic.
module eprf_datapath import eprf_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [1:0]               in_op,
  input  logic                     in_echo_level,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  output logic [CM_BITS-1:0]       out_distance_cm,
  output logic [DIGIT_BITS-1:0]    out_distance_tenths,
  output logic [WIDTH_BITS-1:0]    out_filtered_ticks,
  output logic                     out_timed_out
);

  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] start_r, start_nxt;
  logic [WIDTH_BITS-1:0] width_r, width_nxt;
  logic [WIDTH_BITS-1:0] smooth_r, smooth_nxt;
  logic [MISS_BITS-1:0]  miss_r, miss_nxt;
  logic [MISS_BITS-1:0]  limit_r;
  logic [SCALE_BITS-1:0] scale_r;
  logic                  timed_r, timed_nxt;

  logic [WIDTH_BITS-1:0] tenths_r;
  logic [CM_BITS-1:0]    cm_r;
  logic [DIGIT_BITS-1:0] digit_r;

  logic [COUNT_BITS-1:0] diff;
  logic [31:0]           diff_ext;
  logic [WIDTH_BITS-1:0] width_sat;
  logic [MISS_BITS-1:0]  miss_base;
  logic [31:0]           scale_prod;
  logic [28:0]           cm_prod;
  logic [31:0]           div_prod;
  logic [12:0]           quot;
  logic [15:0]           quot_x10;
  logic [15:0]           rem_full;

  assign stat.poll_update = (width_r != '0) || (miss_r > limit_r);

  assign diff      = tick_r - start_r;
  assign diff_ext  = 32'(diff);
  assign width_sat = (diff_ext > 32'(WIDTH_MAX)) ? WIDTH_MAX : diff_ext[WIDTH_BITS-1:0];
  assign miss_base = stat.poll_update ? '0 : miss_r;

  always_comb begin
    tick_nxt   = tick_r;
    start_nxt  = start_r;
    width_nxt  = width_r;
    smooth_nxt = smooth_r;
    miss_nxt   = miss_r;
    timed_nxt  = timed_r;
    if (cmd.accept) begin
      unique case (in_op)
        OP_TICK: tick_nxt = tick_r + 1'b1;
        OP_EDGE: begin
          if (in_echo_level) begin
            start_nxt = tick_r;
          end else begin
            width_nxt = width_sat;
          end
        end
        OP_POLL: begin
          if (stat.poll_update) begin
            smooth_nxt = (smooth_r >> 2) + (width_r >> 2) + (width_r >> 1);
            width_nxt  = '0;
            timed_nxt  = (width_r == '0);
          end
          miss_nxt = (miss_base < MISS_MAX) ? miss_base + 1'b1 : miss_base;
        end
        default: ;
      endcase
    end
  end

  // Distance arithmetic, one multiply level per stage.
  assign scale_prod = smooth_r * scale_r;
  assign cm_prod    = tenths_r * CM_FACTOR;
  assign div_prod   = tenths_r * DIV10_MUL;
  assign quot       = div_prod[DIV10_SHIFT+12:DIV10_SHIFT];
  assign quot_x10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full   = tenths_r - quot_x10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      start_r  <= '0;
      width_r  <= '0;
      smooth_r <= '0;
      miss_r   <= '0;
      limit_r  <= MISS_LIMIT_RST;
      scale_r  <= TENTHS_SCALE_RST;
    end else begin
      tick_r   <= tick_nxt;
      start_r  <= start_nxt;
      width_r  <= width_nxt;
      smooth_r <= smooth_nxt;
      miss_r   <= miss_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MISS_LIMIT:   limit_r <= cfg_wdata[MISS_BITS-1:0];
          REG_TENTHS_SCALE: scale_r <= cfg_wdata[SCALE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    timed_r <= timed_nxt;
    if (cmd.ld_tenths) begin
      tenths_r <= scale_prod[31:16];
    end
    if (cmd.ld_cm) begin
      cm_r    <= (cm_prod[28:16] > 13'(CM_SAT)) ? CM_SAT : cm_prod[16+CM_BITS-1:16];
      digit_r <= rem_full[DIGIT_BITS-1:0];
    end
    if (cmd.load_out) begin
      out_distance_cm     <= cm_r;
      out_distance_tenths <= digit_r;
      out_filtered_ticks  <= smooth_r;
      out_timed_out       <= timed_r;
    end
  end

endmodule

/* design/eprf_ctrl.sv */
// Controller: sequences an updating poll and owns the handshakes.
module eprf_ctrl import eprf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  output logic       out_valid,
  input  logic       out_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_POLL && stat.poll_update) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_CM;
      ST_CM:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    cmd.accept    = in_valid && (state_r == ST_IDLE);
    cmd.ld_tenths = (state_r == ST_SCALE);
    cmd.ld_cm     = (state_r == ST_CM);
    cmd.load_out  = (state_r == ST_OUT) && out_free;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* dv/eprf_range_checker.sv */
// Checker that predicts and compares the result items of the echo pulse range filter.
module eprf_range_checker import eprf_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic                     in_echo_level,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [CM_BITS-1:0]       out_distance_cm,
  input  logic [DIGIT_BITS-1:0]    out_distance_tenths,
  input  logic [WIDTH_BITS-1:0]    out_filtered_ticks,
  input  logic                     out_timed_out,
  output int                       mismatches,
  output int                       readings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CM_BITS-1:0]    cm;
    logic [DIGIT_BITS-1:0] digit;
    logic [WIDTH_BITS-1:0] ticks;
    logic                  timed_out;
  } reading_t;

  reading_t readings_due[$];

  logic [MISS_BITS-1:0]  miss_limit;
  logic [SCALE_BITS-1:0] tenths_scale;
  logic [COUNT_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] rise_tick;
  logic [WIDTH_BITS-1:0] pulse_width;
  logic [WIDTH_BITS-1:0] smoothed;
  logic [MISS_BITS-1:0]  misses;

  // Advances the shadow state by one accepted item and queues the reading it yields.
  task automatic measure_item(input logic [1:0] op, input logic level);
    logic [COUNT_BITS-1:0] span;
    logic [WIDTH_BITS-1:0] w;
    logic [WIDTH_BITS-1:0] tenths;
    logic [31:0]           sum;
    logic [31:0]           scaled;
    logic [31:0]           cm_full;
    reading_t              r;
    case (op)
      OP_TICK: tick_count = tick_count + 1'b1;
      OP_EDGE: begin
        if (level) begin
          rise_tick = tick_count;
        end else begin
          span = tick_count - rise_tick;
          if (64'(span) > 64'(WIDTH_MAX)) begin
            pulse_width = WIDTH_MAX;
          end else begin
            pulse_width = WIDTH_BITS'(span);
          end
        end
      end
      OP_POLL: begin
        if (pulse_width != '0 || misses > miss_limit) begin
          w        = pulse_width;
          sum      = 32'(smoothed >> 2) + 32'(w >> 2) + 32'(w >> 1);
          smoothed = sum[WIDTH_BITS-1:0];
          scaled   = 32'(smoothed) * 32'(tenths_scale);
          tenths   = scaled[31:16];
          cm_full  = (32'(tenths) * 32'(CM_FACTOR)) >> 16;
          r.cm        = (cm_full > 32'(CM_SAT)) ? CM_SAT : cm_full[CM_BITS-1:0];
          r.digit     = DIGIT_BITS'(tenths % 16'd10);
          r.ticks     = smoothed;
          r.timed_out = (w == '0);
          readings_due.push_back(r);
          pulse_width = '0;
          misses      = '0;
        end
        if (misses < MISS_MAX) begin
          misses = misses + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reading_t due;
    if (!rst_n) begin
      miss_limit   = MISS_LIMIT_RST;
      tenths_scale = TENTHS_SCALE_RST;
      tick_count   = '0;
      rise_tick    = '0;
      pulse_width  = '0;
      smoothed     = '0;
      misses       = '0;
      mismatches   = 0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MISS_LIMIT:   miss_limit = cfg_wdata[MISS_BITS-1:0];
          REG_TENTHS_SCALE: tenths_scale = cfg_wdata[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        measure_item(in_op, in_echo_level);
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $error("result item with no reading due: distance_cm %0d", out_distance_cm);
          mismatches++;
        end else begin
          due = readings_due.pop_front();
          if (out_distance_cm !== due.cm) begin
            $error("distance_cm: expected %0d, got %0d", due.cm, out_distance_cm);
            mismatches++;
          end
          if (out_distance_tenths !== due.digit) begin
            $error("distance_tenths: expected %0d, got %0d", due.digit, out_distance_tenths);
            mismatches++;
          end
          if (out_filtered_ticks !== due.ticks) begin
            $error("filtered_ticks: expected %0d, got %0d", due.ticks, out_filtered_ticks);
            mismatches++;
          end
          if (out_timed_out !== due.timed_out) begin
            $error("timed_out: expected %0d, got %0d", due.timed_out, out_timed_out);
            mismatches++;
          end
        end
      end
    end
    readings_pending = readings_due.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the echo pulse range filter testbench: clock, reset, stimulus and verdict.
module testbench import eprf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The op field has one code the block must ignore.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata     = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op         = OP_TICK;
  logic                     in_echo_level = 1'b0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [CM_BITS-1:0]       out_distance_cm;
  logic [DIGIT_BITS-1:0]    out_distance_tenths;
  logic [WIDTH_BITS-1:0]    out_filtered_ticks;
  logic                     out_timed_out;

  int mismatches;
  int readings_pending;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int in_idle_pct  = 35;
  int out_idle_pct = 81;
  // Items handed to the block so far, the ignored op code not counted.
  int items_sent   = 0;

  always #5ns clk = ~clk;

  echo_pulse_range_filter u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_echo_level       (in_echo_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distance_cm     (out_distance_cm),
    .out_distance_tenths (out_distance_tenths),
    .out_filtered_ticks  (out_filtered_ticks),
    .out_timed_out       (out_timed_out)
  );

  eprf_range_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_echo_level       (in_echo_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distance_cm     (out_distance_cm),
    .out_distance_tenths (out_distance_tenths),
    .out_filtered_ticks  (out_filtered_ticks),
    .out_timed_out       (out_timed_out),
    .mismatches          (mismatches),
    .readings_pending    (readings_pending)
  );

  // The receiver stalls at random, one fresh decision every cycle, so that stalls land
  // on every cycle of the multiply pipeline and on the output register alike.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Hands one item to the block. Valid is only dropped during an idle gap, never in
  // the step where the next item raises it again, and the payload holds while stalled.
  task automatic send_item(input logic [1:0] op, input logic level);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_echo_level <= level;
    do @(posedge clk); while (in_stall);
    if (op != OP_RESERVED) begin
      items_sent++;
    end
  endtask

  // Stops sending and waits until every reading due has come out. The checker counts a
  // reading from the cycle its poll is taken, so a zero count means nothing is in
  // flight; a margin of idle cycles then passes before the caller may touch the registers.
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (readings_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed measurement: rising edge, a run of ticks, falling edge, then polls.
  // The level bit is random wherever the block does not look at it.
  task automatic measure_pulse(input int ticks, input int polls);
    send_item(OP_EDGE, 1'b1);
    repeat (ticks) send_item(OP_TICK, 1'($urandom()));
    send_item(OP_EDGE, 1'b0);
    repeat (polls) send_item(OP_POLL, 1'($urandom()));
  endtask

  // A short random stretch of traffic. Most of it is proper measurements with random
  // widths, so that the filter keeps getting fresh pulses; the rest is noise, broken
  // edge sequences and runs of polls that drive the miss counter toward its limit.
  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(19);
    n    = ($urandom_range(39) == 0) ? $urandom_range(150) : $urandom_range(12);
    if (kind < 13) begin
      measure_pulse(n, 1 + $urandom_range(2));
    end else if (kind < 16) begin
      repeat (1 + $urandom_range(5)) send_item(2'($urandom_range(3)), 1'($urandom()));
    end else if (kind < 18) begin
      case ($urandom_range(2))
        0: begin
          // Falling edge with no rising edge since the last measurement.
          repeat (n) send_item(OP_TICK, 1'($urandom()));
          send_item(OP_EDGE, 1'b0);
          send_item(OP_POLL, 1'($urandom()));
        end
        1: begin
          // A second rising edge moves the start of the pulse.
          send_item(OP_EDGE, 1'b1);
          repeat (n) send_item(OP_TICK, 1'($urandom()));
          measure_pulse($urandom_range(12), 1);
        end
        default: begin
          // The echo never falls before the poll.
          send_item(OP_EDGE, 1'b1);
          repeat (n) send_item(OP_TICK, 1'($urandom()));
          send_item(OP_POLL, 1'($urandom()));
        end
      endcase
    end else begin
      repeat (1 + $urandom_range(7)) send_item(OP_POLL, 1'($urandom()));
    end
  endtask

  task automatic random_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      random_burst();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset nothing has been measured, so polls only count misses until
    // the count passes the reset limit and the fifth poll forces a decaying update.
    repeat (5) send_item(OP_POLL, 1'b0);
    // A falling edge with no rising edge at count zero gives a zero width, which the
    // next poll must treat as no pulse at all.
    send_item(OP_EDGE, 1'b0);
    send_item(OP_POLL, 1'b1);
    // After three ticks the same lone falling edge measures from the reset start.
    repeat (3) send_item(OP_TICK, 1'b1);
    send_item(OP_EDGE, 1'b0);
    send_item(OP_POLL, 1'b0);
    // A pulse of zero length: rising and falling edge at the same count.
    send_item(OP_EDGE, 1'b1);
    send_item(OP_EDGE, 1'b0);
    send_item(OP_POLL, 1'b0);
    // The unused op code must leave everything alone, whatever the level.
    send_item(OP_RESERVED, 1'b1);
    send_item(OP_RESERVED, 1'b0);
    measure_pulse(2, 1);

    // Phase one: the lowest miss limit and the largest scale. Settling here also makes
    // the sender wait until every reading has come back.
    settle();
    write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'(0));
    write_reg(REG_TENTHS_SCALE, 16'hffff);
    random_phase(450);

    // Phase two swaps the idling of the two sides. A zero scale flattens the distance of
    // one measured pulse; after it, with the limit at its top, the miss count saturates
    // and can never pass it.
    settle();
    in_idle_pct  = 81;
    out_idle_pct = 35;
    write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'(MISS_MAX));
    write_reg(REG_TENTHS_SCALE, '0);
    measure_pulse(5, 2);
    repeat (300) send_item(OP_POLL, 1'($urandom()));
    settle();
    // One below the top, the saturated miss count forces an update at the next poll.
    write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'(MISS_MAX - 1'b1));
    write_reg(REG_TENTHS_SCALE, CFG_DATA_BITS'($urandom()));
    repeat (5) send_item(OP_POLL, 1'($urandom()));
    random_phase(150);

    // Phase three: no idling on either side and a random setting.
    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'($urandom_range(6)));
    write_reg(REG_TENTHS_SCALE, CFG_DATA_BITS'($urandom()));
    random_phase(450);

    // A longer pulse at full scale and the reset miss limit, then a last stretch.
    settle();
    write_reg(REG_MISS_LIMIT, CFG_DATA_BITS'(MISS_LIMIT_RST));
    write_reg(REG_TENTHS_SCALE, 16'hffff);
    measure_pulse(250, 2);
    random_phase(40);

    settle();
    if (mismatches == 0 && readings_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
